// ===== rtl/hpt_pkg.sv =====
// ----------------------------------------------------------------------------
// Hashed page table insert: shared definitions
// Word formats, table geometry and the helpers for the primary hash and for
// building the two entry words.
// ----------------------------------------------------------------------------
package hpt_pkg;

	localparam int GROUP_BITS      = 10;
	localparam int SLOTS_PER_GROUP = 8;
	localparam int GROUP_COUNT     = 1 << GROUP_BITS;
	localparam int SLOT_W          = $clog2(SLOTS_PER_GROUP);
	localparam int HASH_W          = 19;
	localparam int HASH_LOW_W      = 10;
	localparam int MASK_W          = HASH_W - HASH_LOW_W;
	localparam int GROUP_IDX_W     = 10;

	localparam logic STATUS_WRITTEN = 1'b0;
	localparam logic STATUS_FULL    = 1'b1;

	localparam logic [3:0] WIMG_DEFAULT = 4'h4;
	localparam logic [1:0] PP_DEFAULT   = 2'h2;

	typedef struct packed {
		logic [23:0] segment_id;
		logic [31:0] virtual_addr;
		logic [31:0] physical_addr;
	} in_word_t;

	typedef struct packed {
		logic                   status;
		logic [GROUP_IDX_W-1:0] group_index;
		logic [2:0]             slot;
		logic [31:0]            entry_high_word;
		logic [31:0]            entry_low_word;
	} out_word_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
	} slot_find_t;

	// Primary hash: low VSID bits XOR page index, upper nine bits masked.
	function automatic logic [GROUP_BITS-1:0] hpt_group(
		input logic [23:0]       vsid,
		input logic [31:0]       va,
		input logic [MASK_W-1:0] mask
	);
		logic [HASH_W-1:0] h;
		logic [HASH_W-1:0] g;
		h = vsid[HASH_W-1:0] ^ {3'b000, va[27:12]};
		g = {h[HASH_W-1:HASH_LOW_W] & mask, h[HASH_LOW_W-1:0]};
		return g[GROUP_BITS-1:0];
	endfunction

	function automatic logic [31:0] hpt_high_word(
		input logic [23:0] vsid,
		input logic [31:0] va
	);
		return {1'b1, vsid, 1'b0, va[27:22]};
	endfunction

	function automatic logic [31:0] hpt_low_word(input logic [31:0] pa);
		return {pa[31:12], 5'b00000, WIMG_DEFAULT, 1'b0, PP_DEFAULT};
	endfunction

endpackage

// ===== rtl/hpt_slot_find.sv =====
// ----------------------------------------------------------------------------
// Hashed page table insert: free slot finder
// Picks the lowest-numbered free slot of one group's occupancy row.
// ----------------------------------------------------------------------------
module hpt_slot_find (
	input  logic [hpt_pkg::SLOTS_PER_GROUP-1:0] row,
	output hpt_pkg::slot_find_t                 find
);
	import hpt_pkg::*;

	always_comb begin
		find = '0;
		// Walking downwards leaves the lowest free slot as the winner.
		for (int i = SLOTS_PER_GROUP - 1; i >= 0; i--) begin
			if (!row[i]) begin
				find.found = 1'b1;
				find.slot  = SLOT_W'(i);
			end
		end
	end

endmodule

// ===== rtl/hpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Hashed page table insert: sequencer and occupancy store
// Clears the occupancy map after reset, then for each word reads the group's
// row, finds a free slot, writes the row back when one was found and builds the result word.
// ----------------------------------------------------------------------------
module hpt_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [hpt_pkg::MASK_W-1:0]    hash_mask,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  hpt_pkg::in_word_t             in_data,
	output logic                          res_valid,
	input  logic                          res_free,
	output hpt_pkg::out_word_t            res
);
	import hpt_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_SCAN,
		S_DONE
	} state_t;

	state_t                 state_q;
	logic [GROUP_BITS-1:0]  clr_addr_q;
	logic [GROUP_BITS-1:0]  group_q;
	in_word_t               item_q;
	logic [SLOTS_PER_GROUP-1:0] row_q;
	out_word_t              res_q;

	// One row of valid bits per group; the entry words themselves go out
	// with the result.
	logic [SLOTS_PER_GROUP-1:0] occ_mem [GROUP_COUNT];

	logic                       mem_we;
	logic [GROUP_BITS-1:0]      mem_waddr;
	logic [SLOTS_PER_GROUP-1:0] mem_wdata;
	slot_find_t                 find;

	hpt_slot_find u_slot_find (
		.row  (row_q),
		.find (find)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = group_q;
		mem_wdata = row_q | (SLOTS_PER_GROUP'(1) << find.slot);
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else if (state_q == S_SCAN) begin
			mem_we = find.found;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			occ_mem[mem_waddr] <= mem_wdata;
		end
		if (state_q == S_READ) begin
			row_q <= occ_mem[group_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_addr_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == {GROUP_BITS{1'b1}}) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						item_q  <= in_data;
						group_q <= hpt_group(in_data.segment_id, in_data.virtual_addr,
							hash_mask);
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					res_q.group_index <= group_q[GROUP_IDX_W-1:0];
					if (find.found) begin
						res_q.status          <= STATUS_WRITTEN;
						res_q.slot            <= find.slot;
						res_q.entry_high_word <= hpt_high_word(item_q.segment_id,
							item_q.virtual_addr);
						res_q.entry_low_word  <= hpt_low_word(item_q.physical_addr);
					end else begin
						res_q.status          <= STATUS_FULL;
						res_q.slot            <= '0;
						res_q.entry_high_word <= '0;
						res_q.entry_low_word  <= '0;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// An accepted word always goes straight to the row read.
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_READ)
		else $error("accepted word did not start a row read");

	// A write-back during a scan sets exactly one new bit in the row.
	a_one_bit_set: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN && mem_we |-> $countones(mem_wdata ^ row_q) == 1)
		else $error("row write-back changed other than one slot");

	// A full status is reported exactly when the group row was full.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |-> (res_q.status == STATUS_FULL) == (&row_q))
		else $error("status disagrees with the group occupancy");

	// No word is taken while a result is still owed.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !in_ready)
		else $error("input ready while a result is pending");

endmodule

// ===== rtl/hashed_page_table_insert_top.sv =====
// ----------------------------------------------------------------------------
// Hashed page table insert: top level
// Inserts one translation per input word into a hashed table of eight-entry
// groups and returns the group, slot and entry words, or a group-full status.
//
//   Channel  Direction  Word         Content
//   cfg      in         cfg_data     hash_mask, nine bits
//   in       in         in_data      segment_id, virtual_addr, physical_addr
//   out      out        out_data     status, group_index, slot, entry words
//
// An insert passes through accept, occupancy row read, slot pick with
// write-back, and hand-over of the result. The result is registered in the
// controller's result register, then moved into the output register.
// Per word the single-port occupancy memory sees one read, then at most one write.
// After reset a clearing pass over all 1024 groups empties the occupancy map; no
// input word is accepted meanwhile, configuration writes are taken as ever.
// A stalled output holds the result; the next input word is accepted once the
// result has moved into the output register.
// ----------------------------------------------------------------------------
module hashed_page_table_insert_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [hpt_pkg::MASK_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  hpt_pkg::in_word_t          in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output hpt_pkg::out_word_t         out_data
);
	import hpt_pkg::*;

	logic [MASK_W-1:0] hash_mask_q;
	logic              out_valid_q;
	out_word_t         out_data_q;
	logic              res_valid;
	logic              res_free;
	out_word_t         res;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign res_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_mask_q <= '0;
		end else if (cfg_valid) begin
			hash_mask_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && res_valid) begin
			out_data_q <= res;
		end
	end

	hpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.hash_mask (hash_mask_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.res_valid (res_valid),
		.res_free  (res_free),
		.res       (res)
	);

endmodule
